[hdl/mf3x3_pkg.sv]
// Shared types, constants and helper functions for the 3x3 minimum filter.
// Used by mf3x3_cell and min_filter_3x3_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mf3x3_pkg;

   // Image geometry limits.
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4095;
   localparam int MIN_SIZE     = 3;
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 768;

   // Field and register widths.
   localparam int PIX_W       = 8;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_REG_W = 11;
   localparam int ROW_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;

   // Both line stores live side by side in one memory word.
   localparam int LINE_W = 2 * PIX_W;

   // Cells in the window chain: the two columns before the current one.
   localparam int NUM_CELLS = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // Pixel value type.
   typedef logic [PIX_W-1:0] pix_type;

   // One request on its way from the accept stage to the window stage.
   typedef struct packed {
      logic                valid;
      logic                emit;
      logic                last;
      pix_type             pixel;
      logic [COL_W-1:0]    col;
      logic [COL_W-1:0]    out_col;
      logic [ROW_W-1:0]    out_row;
   } stage_type;

   // Smaller of two pixels.
   function automatic pix_type min_pix(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

[hdl/min_filter_3x3_unit.sv]
// Streaming 3x3 minimum filter: top level with counters, line stores and window chain.
// Depends on mf3x3_pkg, mf3x3_ram and mf3x3_cell.
//
// Usage:
// Pixels enter in raster order on the req_ channel (req_valid, req_stall,
// req_pixel_in), one request per clock when nothing is stalled. For each
// interior pixel the rsp_ channel delivers the minimum of its 3x3
// neighbourhood with its column, its row and a flag on the final interior
// pixel of the frame; border pixels give no response.
// A response is registered in two steps: the edge that accepts the request
// completing its window reads the line stores and loads the accept stage; a later
// edge on which the pipeline advances folds the column minima through the window chain into the output register.
// Throughput is one pixel per clock while no response is stalled, set by the
// single read and write port of the line-store memory.
// Image width and height are written through the csr_ channel while idle;
// csr_ready is always high. Widths are clamped to 3..1024, heights to at least 3.
// Reset clears the counters and the valid flags and restores the register
// defaults (1024 by 768); the line stores need no clearing pass.
// While a response waits under rsp_stall the whole pipeline holds and
// req_stall is raised; otherwise req_stall stays low.
`timescale 1ns / 1ps
`default_nettype none

module min_filter_3x3_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Pixel requests
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [mf3x3_pkg::PIX_W-1:0]           req_pixel_in,
   // Filter responses
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [mf3x3_pkg::PIX_W-1:0]           rsp_min_value,
   output logic      [mf3x3_pkg::COL_W-1:0]           rsp_out_col,
   output logic      [mf3x3_pkg::ROW_W-1:0]           rsp_out_row,
   output logic                                       rsp_last_of_frame,
   // Configuration writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mf3x3_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mf3x3_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int COL_W = mf3x3_pkg::COL_W;
   localparam int ROW_W = mf3x3_pkg::ROW_W;
   localparam int WRW   = mf3x3_pkg::WIDTH_REG_W;
   localparam int PIX_W = mf3x3_pkg::PIX_W;

   // Configuration registers.
   logic [WRW-1:0]   width_ff,  width_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic [WRW-1:0]   w_eff;
   logic [ROW_W-1:0] h_eff;

   // Raster position counters.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [WRW-1:0]   col_inc;
   logic [ROW_W:0]   row_inc;

   // Pipeline control and registers.
   logic                  advance;
   logic                  accept;
   mf3x3_pkg::stage_type  s1_ff, s1_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mf3x3_pkg::pix_type    rsp_min_ff, rsp_min_in;
   logic [COL_W-1:0]      rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]      rsp_row_ff, rsp_row_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Line-store memory and window chain.
   logic [mf3x3_pkg::LINE_W-1:0] line_rd;
   logic [mf3x3_pkg::LINE_W-1:0] line_wr;
   logic                         line_wr_en;
   mf3x3_pkg::pix_type           top_pix, mid_pix;
   mf3x3_pkg::pix_type           link_min [mf3x3_pkg::NUM_CELLS+1];
   mf3x3_pkg::pix_type           link_acc [mf3x3_pkg::NUM_CELLS+1];
   logic                         window_shift;

   // The pipeline moves unless a response sits stalled in the output register.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == mf3x3_pkg::CSR_IMAGE_WIDTH) begin
            width_in = csr_data[WRW-1:0];
         end else if (csr_index == mf3x3_pkg::CSR_IMAGE_HEIGHT) begin
            height_in = csr_data[ROW_W-1:0];
         end
      end
   end

   // Effective geometry; the height register cannot exceed the maximum height.
   always_comb begin
      priority if (width_ff < WRW'(mf3x3_pkg::MIN_SIZE)) begin
         w_eff = WRW'(mf3x3_pkg::MIN_SIZE);
      end else if (width_ff > WRW'(mf3x3_pkg::MAX_WIDTH)) begin
         w_eff = WRW'(mf3x3_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < ROW_W'(mf3x3_pkg::MIN_SIZE)) ?
              ROW_W'(mf3x3_pkg::MIN_SIZE) : height_ff;
   end

   // Column and row counters, with wrap at the end of a row and of a frame.
   always_comb begin
      col_inc = {1'b0, col_ff} + WRW'(1);
      row_inc = {1'b0, row_ff} + (ROW_W+1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            if (row_ff >= h_eff) begin
               row_in = '0;
            end
         end
      end
   end

   // Accept stage: tag the request with its position and window outcome.
   always_comb begin
      s1_in = s1_ff;
      if (advance) begin
         s1_in.valid   = accept;
         s1_in.emit    = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
         s1_in.last    = (col_inc == w_eff) && (row_inc == {1'b0, h_eff});
         s1_in.pixel   = req_pixel_in;
         s1_in.col     = col_ff;
         s1_in.out_col = col_ff - COL_W'(1);
         s1_in.out_row = row_ff - ROW_W'(1);
      end
   end

   // Line stores: upper in the high byte, middle in the low byte.
   mf3x3_ram #(
      .WIDTH (mf3x3_pkg::LINE_W),
      .DEPTH (mf3x3_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (line_wr),
      .rd_en   (advance),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign top_pix    = line_rd[mf3x3_pkg::LINE_W-1:PIX_W];
   assign mid_pix    = line_rd[PIX_W-1:0];
   // The middle row moves up and the new pixel becomes the middle row.
   assign line_wr    = {mid_pix, s1_ff.pixel};
   assign line_wr_en = advance && s1_ff.valid;

   // Window chain: current column minimum enters, older columns fold in.
   assign window_shift = advance && s1_ff.valid;
   assign link_min[0]  = mf3x3_pkg::min_pix(mf3x3_pkg::min_pix(top_pix, mid_pix),
                                            s1_ff.pixel);
   assign link_acc[0]  = link_min[0];

   for (genvar k = 0; k < mf3x3_pkg::NUM_CELLS; k++) begin : g_cell
      mf3x3_cell u_cell (
         .clock         (clock),
         .shift         (window_shift),
         .min_from_prev (link_min[k]),
         .min_to_next   (link_min[k+1]),
         .acc_from_prev (link_acc[k]),
         .acc_to_next   (link_acc[k+1])
      );
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = s1_ff.valid && s1_ff.emit;
         rsp_min_in   = link_acc[mf3x3_pkg::NUM_CELLS];
         rsp_col_in   = s1_ff.out_col;
         rsp_row_in   = s1_ff.out_row;
         rsp_last_in  = s1_ff.last;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WRW'(mf3x3_pkg::WIDTH_RESET);
         height_ff    <= ROW_W'(mf3x3_pkg::HEIGHT_RESET);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_min_ff  <= rsp_min_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_value     = rsp_min_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef SYNTH
   // A response always names an interior pixel.
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_col_ff != '0) && (rsp_row_ff != '0))
      else $error("response names a border pixel");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response pending after reset");

   // A held response freezes the accept stage.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(s1_ff))
      else $error("accept stage moved under a stalled response");

   // A fresh response comes only from an emitting request in the accept stage.
   a_fresh_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(s1_ff.valid && s1_ff.emit))
      else $error("response without a source request");
`endif

endmodule

`default_nettype wire

[hdl/mf3x3_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
`timescale 1ns / 1ps
`default_nettype none

module mf3x3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mf3x3_cell.sv]
// One cell of the window chain: holds the minimum of one pixel column.
// Depends on mf3x3_pkg for the pixel type and the minimum function.
`timescale 1ns / 1ps
`default_nettype none

module mf3x3_cell (
   input  wire logic               clock,
   input  wire logic               shift,
   input  wire mf3x3_pkg::pix_type min_from_prev,
   output mf3x3_pkg::pix_type      min_to_next,
   input  wire mf3x3_pkg::pix_type acc_from_prev,
   output mf3x3_pkg::pix_type      acc_to_next
);

   mf3x3_pkg::pix_type col_min_ff;
   mf3x3_pkg::pix_type col_min_in;

   // Take the neighbour's column when the window moves on by one pixel.
   always_comb begin
      col_min_in = shift ? min_from_prev : col_min_ff;
   end

   always_ff @(posedge clock) begin
      col_min_ff <= col_min_in;
   end

   // Hand the stored column on and fold it into the running minimum.
   assign min_to_next = col_min_ff;
   assign acc_to_next = mf3x3_pkg::min_pix(acc_from_prev, col_min_ff);

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the streaming 3x3 minimum filter (min_filter_3x3_unit).
// A clocked driver, receiver and monitor are checked against an in-bench model of the filter.
// Depends on mf3x3_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb;
   import mf3x3_pkg::*;

   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int RANDOM_PIXELS   = 220;
   localparam int HOLD_OFF_CYCLES = 300;

   // Register indexes that the block does not decode.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct {
      pix_type          min_value;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
   } window_result_type;

   // Clock, reset and the block's ports.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   pix_type               req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pix_type               rsp_min_value;
   logic [COL_W-1:0]      rsp_out_col;
   logic [ROW_W-1:0]      rsp_out_row;
   logic                  rsp_last_of_frame;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Stimulus and checking bookkeeping.
   pix_type               pixel_backlog [$];
   window_result_type     expected_minima [$];
   int unsigned           items_queued = 0;
   int unsigned           pixels_accepted = 0;
   int unsigned           results_checked = 0;
   int unsigned           frames_seen = 0;
   int unsigned           csr_writes = 0;
   int unsigned           errors = 0;
   int unsigned           cycle_count = 0;
   logic                  req_fired = 1'b0;
   bit                    send_gaps_on = 1'b0;
   bit                    recv_stalls_on = 1'b0;
   bit                    hold_off_go = 1'b0;
   logic                  receiver_hold = 1'b0;
   int unsigned           gap_left = 0;
   int unsigned           stall_left = 0;

   // Fixed pixels for the three directed 3x3 frames.
   pix_type directed_pixels [27] = '{
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
      8'hA5, 8'h5A, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hC3, 8'h3C, 8'h81
   };

   // Shadow state of the filter: geometry registers, line stores, window and position.
   logic [WIDTH_REG_W-1:0] width_reg = WIDTH_REG_W'(WIDTH_RESET);
   logic [ROW_W-1:0]       height_reg = ROW_W'(HEIGHT_RESET);
   pix_type                upper_row [MAX_WIDTH];
   pix_type                middle_row [MAX_WIDTH];
   pix_type                window_cols [6];
   int unsigned            col_pos = 0;
   int unsigned            row_pos = 0;

   min_filter_3x3_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_min_value     (rsp_min_value),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   // Geometry as the block uses it, after clamping.
   function automatic int unsigned effective_width();
      int unsigned w;
      w = width_reg;
      if (w < MIN_SIZE) return MIN_SIZE;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned effective_height();
      int unsigned h;
      h = height_reg;
      if (h < MIN_SIZE) return MIN_SIZE;
      if (h > MAX_HEIGHT) return MAX_HEIGHT;
      return h;
   endfunction

   // Raster position after one pixel; a row or column beyond the geometry wraps to zero.
   function automatic void advance_position(inout int unsigned c, inout int unsigned r,
                                            input int unsigned w, input int unsigned h);
      c = c + 1;
      if (c >= w) begin
         c = 0;
         r = r + 1;
         if (r >= h) r = 0;
      end else if (r >= h) begin
         r = 0;
      end
   endfunction

   // Pixels still needed to bring the raster position back to the top left corner.
   function automatic int unsigned pixels_to_frame_start();
      int unsigned c, r, n;
      c = col_pos;
      r = row_pos;
      n = 0;
      while (c != 0 || r != 0) begin
         advance_position(c, r, effective_width(), effective_height());
         n++;
      end
      return n;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
         CSR_IMAGE_HEIGHT: height_reg = data[ROW_W-1:0];
         default: ;
      endcase
   endfunction

   // Feeds one accepted pixel through the shadow filter and records any minimum it completes.
   function automatic void compute_window_minimum(pix_type pixel);
      int unsigned       w, h, addr;
      pix_type           top, mid, least;
      window_result_type res;
      w = effective_width();
      h = effective_height();
      addr = col_pos % MAX_WIDTH;
      top = upper_row[addr];
      mid = middle_row[addr];
      upper_row[addr] = mid;
      middle_row[addr] = pixel;
      if (col_pos >= 2 && row_pos >= 2) begin
         least = pixel;
         if (top < least) least = top;
         if (mid < least) least = mid;
         foreach (window_cols[k])
            if (window_cols[k] < least) least = window_cols[k];
         res.min_value = least;
         res.col = COL_W'(col_pos - 1);
         res.row = ROW_W'(row_pos - 1);
         res.last = (col_pos + 1 == w) && (row_pos + 1 == h);
         expected_minima.push_back(res);
      end
      window_cols[0] = window_cols[3];
      window_cols[1] = window_cols[4];
      window_cols[2] = window_cols[5];
      window_cols[3] = top;
      window_cols[4] = mid;
      window_cols[5] = pixel;
      advance_position(col_pos, row_pos, w, h);
   endfunction

   // Compares one accepted response with the oldest expected minimum.
   function automatic void check_response();
      window_result_type want;
      if (expected_minima.size() == 0) begin
         $display("%0t: unexpected response, min %0d at column %0d row %0d", $time,
                  rsp_min_value, rsp_out_col, rsp_out_row);
         errors++;
         return;
      end
      want = expected_minima.pop_front();
      if (rsp_min_value !== want.min_value) begin
         $display("%0t: min_value expected %0d, got %0d", $time, want.min_value, rsp_min_value);
         errors++;
      end
      if (rsp_out_col !== want.col) begin
         $display("%0t: out_col expected %0d, got %0d", $time, want.col, rsp_out_col);
         errors++;
      end
      if (rsp_out_row !== want.row) begin
         $display("%0t: out_row expected %0d, got %0d", $time, want.row, rsp_out_row);
         errors++;
      end
      if (rsp_last_of_frame !== want.last) begin
         $display("%0t: last_of_frame expected %0b, got %0b", $time, want.last,
                  rsp_last_of_frame);
         errors++;
      end
      results_checked++;
      if (want.last) frames_seen++;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int unsigned pick_idle(bit enabled, int unsigned quiet_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enabled || r < quiet_pct) return 0;
      if (r < 96) return $urandom_range(1, 4);
      if (r < 99) return $urandom_range(5, 16);
      return $urandom_range(20, 60);
   endfunction

   function automatic pix_type random_pixel(int unsigned floor_value);
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'hFF;
      if (r == 1) return pix_type'(floor_value);
      return pix_type'($urandom_range(floor_value, 255));
   endfunction

   function automatic void push_pixel(pix_type p);
      pixel_backlog.push_back(p);
      items_queued++;
   endfunction

   // Monitor: configuration writes, responses and accepted requests, all at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            csr_writes++;
         end
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall) begin
            compute_window_minimum(req_pixel_in);
            pixels_accepted++;
         end
      end
   end

   // Driver: offers the next pending pixel once the current request has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (req_valid && !req_fired) begin
         // The request is still waiting, so it stays as it is.
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pixel_backlog.size() != 0) begin
         req_pixel_in <= pixel_backlog.pop_front();
         req_valid <= 1'b1;
         gap_left = pick_idle(send_gaps_on, 65);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stalls on the response side, or a long hold-off when one is running.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (receiver_hold) begin
         rsp_stall <= 1'b1;
      end else begin
         if (stall_left == 0) stall_left = pick_idle(recv_stalls_on, 75);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here once the stimulus arms it.
   initial begin : receiver_hold_off
      wait (hold_off_go);
      @(negedge clock);
      receiver_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      receiver_hold <= 1'b0;
   end

   // Watchdog on the overall run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles without finishing", $time, CYCLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(bit gaps, bit stalls);
      @(posedge clock);
      send_gaps_on = gaps;
      recv_stalls_on = stalls;
   endtask

   task automatic queue_random(int unsigned n, int unsigned floor_value);
      @(posedge clock);
      repeat (n) push_pixel(random_pixel(floor_value));
   endtask

   // Waits until every pixel is taken and every minimum has arrived, then lets the pipe drain.
   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_accepted != items_queued || expected_minima.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_frames(logic [CSR_DATA_W-1:0] w_data, logic [CSR_DATA_W-1:0] h_data,
                             int unsigned frames, bit gaps, bit stalls);
      write_register(CSR_IMAGE_WIDTH, w_data);
      write_register(CSR_IMAGE_HEIGHT, h_data);
      set_idling(gaps, stalls);
      queue_random(frames * effective_width() * effective_height(),
                   $urandom_range(0, 1) ? 0 : $urandom_range(100, 240));
      wait_idle();
   endtask

   initial begin : stimulus
      int unsigned random_queued, n, partial;
      logic [CSR_DATA_W-1:0] w_data, h_data;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default geometry straight out of reset: the start of the first row.
      set_idling(1'b1, 1'b1);
      queue_random(40, 0);
      wait_idle();

      // Geometry shrunk in the middle of a frame, plus writes to undecoded indexes.
      write_register(CSR_IMAGE_WIDTH, 12'd5);
      write_register(CSR_IMAGE_HEIGHT, 12'd6);
      write_register(CSR_SPARE_LOW, CSR_DATA_W'($urandom_range(0, 4095)));
      write_register(CSR_SPARE_HIGH, CSR_DATA_W'($urandom_range(0, 4095)));
      queue_random(pixels_to_frame_start(), 0);
      wait_idle();

      // Smallest frames with fixed contents: all white, a dark corner, mixed bit patterns.
      write_register(CSR_IMAGE_WIDTH, 12'd3);
      write_register(CSR_IMAGE_HEIGHT, 12'd3);
      @(posedge clock);
      foreach (directed_pixels[i]) push_pixel(directed_pixels[i]);
      wait_idle();

      // Sizes below the minimum clamp up.
      run_frames(12'd0, 12'd1, 1, 1'b1, 1'b1);

      // Widest and tallest settings: the start of a frame, then a cut to a small geometry.
      write_register(CSR_IMAGE_WIDTH, 12'hFFF);
      write_register(CSR_IMAGE_HEIGHT, 12'hFFF);
      set_idling(1'b0, 1'b0);
      queue_random(50, 0);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, 12'd7);
      write_register(CSR_IMAGE_HEIGHT, 12'd4);
      queue_random(pixels_to_frame_start(), 0);
      wait_idle();

      // Receiver holds off for a long stretch while pixels keep coming.
      write_register(CSR_IMAGE_WIDTH, 12'd24);
      write_register(CSR_IMAGE_HEIGHT, 12'd10);
      set_idling(1'b0, 1'b0);
      hold_off_go = 1'b1;
      queue_random(effective_width() * effective_height(), 0);
      wait_idle();

      // Random geometries, whole frames or a frame cut by a geometry change.
      random_queued = 0;
      while (random_queued < RANDOM_PIXELS) begin
         w_data = ($urandom_range(0, 4) == 0) ? CSR_DATA_W'($urandom_range(0, 16)) :
                                                CSR_DATA_W'($urandom_range(3, 12));
         h_data = ($urandom_range(0, 9) == 0) ? CSR_DATA_W'($urandom_range(0, 2)) :
                                                CSR_DATA_W'($urandom_range(3, 9));
         write_register(CSR_IMAGE_WIDTH, w_data);
         write_register(CSR_IMAGE_HEIGHT, h_data);
         set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0) begin
            // The sender pauses mid-frame until all minima are in, then the geometry changes.
            partial = $urandom_range(1, effective_width() * effective_height() - 1);
            queue_random(partial, 0);
            wait_idle();
            write_register(CSR_IMAGE_WIDTH,
                           CSR_DATA_W'($urandom_range(MIN_SIZE, effective_width())));
            write_register(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(MIN_SIZE, 12)));
            n = pixels_to_frame_start();
            queue_random(n, $urandom_range(0, 1) ? 0 : $urandom_range(100, 240));
            random_queued += partial + n;
         end else begin
            n = $urandom_range(1, 2) * effective_width() * effective_height();
            queue_random(n, $urandom_range(0, 1) ? 0 : $urandom_range(100, 240));
            random_queued += n;
         end
         wait_idle();
      end

      if (expected_minima.size() != 0) begin
         $display("%0t: %0d expected minima never arrived", $time, expected_minima.size());
         errors += expected_minima.size();
      end
      $display("Filtered %0d pixels, checked %0d minima over %0d completed frames,",
               pixels_accepted, results_checked, frames_seen);
      $display("with %0d register writes, from clamped 3x3 frames to the top of a 1024-wide one.",
               csr_writes);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[min_filter_3x3_unit.f]
hdl/mf3x3_pkg.sv
hdl/mf3x3_ram.sv
hdl/mf3x3_cell.sv
hdl/min_filter_3x3_unit.sv
sim/tb.sv
